@@ hdl/drtt_pkg.sv @@
// ----------------------------------------------------------------------------
// drtt_pkg
// Shared types and constants of the rule transition time block: controller
// states, datapath commands, status bundle and field widths.
// ----------------------------------------------------------------------------
package drtt_pkg;

	localparam int KIND_W  = 2;
	localparam int MONTH_W = 4;
	localparam int WEEK_W  = 3;
	localparam int DAY_W   = 9;
	localparam int TOD_W   = 21;
	localparam int YEAR_W  = 14;
	localparam int SEC_W   = 26;

	localparam logic [KIND_W-1:0] KIND_MWD    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_JULIAN = 2'd1;

	localparam logic signed [SEC_W-1:0] SEC_MAX = 26'sd33554431;
	localparam logic signed [SEC_W-1:0] SEC_MIN = -26'sd33554432;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_PREP,
		ST_DOW,
		ST_FIRST,
		ST_WEEK,
		ST_MONTH,
		ST_MUL,
		ST_SUM,
		ST_DONE
	} drtt_state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_DIV,
		CMD_PREP,
		CMD_DOW,
		CMD_FIRST,
		CMD_WEEK,
		CMD_MONTH,
		CMD_MUL,
		CMD_SUM
	} drtt_cmd_t;

	typedef struct packed {
		logic is_mwd;
		logic week_go;
		logic month_go;
	} drtt_stat_t;

endpackage

@@ hdl/drtt_ctrl.sv @@
// ----------------------------------------------------------------------------
// drtt_ctrl
// Sequencer of the rule transition time block: steps the datapath through
// year split, weekday search, week and month walks, scaling and output.
// ----------------------------------------------------------------------------
module drtt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  drtt_pkg::drtt_stat_t stat,
	output drtt_pkg::drtt_cmd_t  cmd,
	output logic               busy,
	output logic               done
);

	drtt_pkg::drtt_state_t state_q;
	drtt_pkg::drtt_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drtt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = drtt_pkg::CMD_NONE;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			drtt_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd     = drtt_pkg::CMD_LOAD;
					state_d = drtt_pkg::ST_DIV;
				end
			end
			drtt_pkg::ST_DIV: begin
				cmd     = drtt_pkg::CMD_DIV;
				state_d = drtt_pkg::ST_PREP;
			end
			drtt_pkg::ST_PREP: begin
				cmd     = drtt_pkg::CMD_PREP;
				state_d = stat.is_mwd ? drtt_pkg::ST_DOW : drtt_pkg::ST_MUL;
			end
			drtt_pkg::ST_DOW: begin
				cmd     = drtt_pkg::CMD_DOW;
				state_d = drtt_pkg::ST_FIRST;
			end
			drtt_pkg::ST_FIRST: begin
				cmd     = drtt_pkg::CMD_FIRST;
				state_d = drtt_pkg::ST_WEEK;
			end
			drtt_pkg::ST_WEEK: begin
				if (stat.week_go) begin
					cmd = drtt_pkg::CMD_WEEK;
				end else begin
					state_d = drtt_pkg::ST_MONTH;
				end
			end
			drtt_pkg::ST_MONTH: begin
				if (stat.month_go) begin
					cmd = drtt_pkg::CMD_MONTH;
				end else begin
					state_d = drtt_pkg::ST_MUL;
				end
			end
			drtt_pkg::ST_MUL: begin
				cmd     = drtt_pkg::CMD_MUL;
				state_d = drtt_pkg::ST_SUM;
			end
			drtt_pkg::ST_SUM: begin
				cmd     = drtt_pkg::CMD_SUM;
				state_d = drtt_pkg::ST_DONE;
			end
			drtt_pkg::ST_DONE: begin
				done    = 1'b1;
				state_d = drtt_pkg::ST_IDLE;
			end
			default: begin
				state_d = drtt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/drtt_dp.sv @@
// ----------------------------------------------------------------------------
// drtt_dp
// Datapath of the rule transition time block: operand registers, year split
// by reciprocal multiply, weekday congruence, day accumulator, scaling and
// saturation.
// ----------------------------------------------------------------------------
module drtt_dp (
	input  logic                                   clk,
	input  drtt_pkg::drtt_cmd_t                    cmd,
	input  logic [drtt_pkg::KIND_W-1:0]            rule_kind,
	input  logic [drtt_pkg::MONTH_W-1:0]           rule_month,
	input  logic [drtt_pkg::WEEK_W-1:0]            rule_week,
	input  logic [drtt_pkg::DAY_W-1:0]             rule_day,
	input  logic signed [drtt_pkg::TOD_W-1:0]      rule_time,
	input  logic [drtt_pkg::YEAR_W-1:0]            calendar_year,
	output drtt_pkg::drtt_stat_t                   stat,
	output logic signed [drtt_pkg::SEC_W-1:0]      seconds_into_year
);

	localparam logic signed [17:0] DAY_SECONDS = 18'sd86400;
	localparam logic [12:0] LONG_MONTHS = 13'b1010110101010;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		if (m == 4'd2) begin
			len = 5'd28 + {4'd0, leap};
		end else begin
			len = 5'd30 + {4'd0, LONG_MONTHS[m]};
		end
		return len;
	endfunction

	function automatic logic [2:0] mod7(input logic [9:0] x);
		logic [19:0] p;
		logic [6:0]  q;
		logic [9:0]  r;
		p = x * 10'd586;
		q = p[18:12];
		r = x - 10'({3'd0, q} * 10'd7);
		return r[2:0];
	endfunction

	function automatic logic [5:0] month_base(input logic [3:0] m);
		logic [5:0] c;
		case (m)
			4'd1:    c = 6'd29;
			4'd2:    c = 6'd32;
			4'd3:    c = 6'd3;
			4'd4:    c = 6'd6;
			4'd5:    c = 6'd8;
			4'd6:    c = 6'd11;
			4'd7:    c = 6'd13;
			4'd8:    c = 6'd16;
			4'd9:    c = 6'd19;
			4'd10:   c = 6'd21;
			4'd11:   c = 6'd24;
			4'd12:   c = 6'd26;
			default: c = 6'd26;
		endcase
		return c;
	endfunction

	logic [drtt_pkg::KIND_W-1:0]       kind_q;
	logic [3:0]                        month_q;
	logic [2:0]                        week_q;
	logic [drtt_pkg::DAY_W-1:0]        rday_q;
	logic signed [drtt_pkg::TOD_W-1:0] tod_q;
	logic [drtt_pkg::YEAR_W-1:0]       year_q;
	logic [7:0]                        q100_q;
	logic                              leap_q;
	logic [9:0]                        x_q;
	logic signed [10:0]                days_q;
	logic [2:0]                        wk_q;
	logic [3:0]                        m_q;
	logic signed [27:0]                prod_q;
	logic signed [drtt_pkg::SEC_W-1:0] res_q;

	logic [27:0] yprod;
	logic [13:0] r100_full;
	logic [6:0]  r100;
	logic        leap_w;
	logic        ay_neg;
	logic [6:0]  ar;
	logic [7:0]  aq;
	logic [5:0]  cbase;
	logic [11:0] x_sum;
	logic [10:0] jdays;
	logic [4:0]  ml_cur;
	logic [4:0]  ml_walk;
	logic [28:0] total;

	assign yprod     = year_q * 14'd10486;
	assign r100_full = year_q - 14'({6'd0, q100_q} * 14'd100);
	assign r100      = r100_full[6:0];
	assign leap_w    = ((year_q[1:0] == 2'd0) && (r100 != 7'd0))
		|| ((r100 == 7'd0) && (q100_q[1:0] == 2'd0));
	assign cbase     = month_base(month_q);

	always_comb begin
		ay_neg = 1'b0;
		ar     = r100;
		aq     = q100_q;
		if (month_q <= 4'd2) begin
			if (year_q == '0) begin
				ay_neg = 1'b1;
			end else if (r100 != 7'd0) begin
				ar = r100 - 7'd1;
			end else begin
				ar = 7'd99;
				aq = q100_q - 8'd1;
			end
		end
		if (ay_neg) begin
			x_sum = 12'd350 + {6'd0, cbase} - 12'd1;
		end else begin
			x_sum = 12'd350 + {6'd0, cbase} + {5'd0, ar} + {7'd0, ar[6:2]}
				+ {6'd0, aq[7:2]} - {3'd0, aq, 1'b0};
		end
	end

	assign jdays   = {2'd0, rday_q} - 11'd1 + {10'd0, (rday_q >= 9'd60) && leap_w};
	assign ml_cur  = month_len(month_q, leap_q);
	assign ml_walk = month_len(m_q, leap_q);
	assign total   = {prod_q[27], prod_q} + 29'(tod_q);

	assign stat.is_mwd   = (kind_q == drtt_pkg::KIND_MWD);
	assign stat.week_go  = (wk_q > 3'd1) && ((days_q[8:0] + 9'd7) < {4'd0, ml_cur});
	assign stat.month_go = (m_q < month_q);

	always_ff @(posedge clk) begin
		case (cmd)
			drtt_pkg::CMD_LOAD: begin
				kind_q <= rule_kind;
				if (rule_month == 4'd0) begin
					month_q <= 4'd1;
				end else if (rule_month > 4'd12) begin
					month_q <= 4'd12;
				end else begin
					month_q <= rule_month;
				end
				week_q <= (rule_week == 3'd0) ? 3'd1 : rule_week;
				rday_q <= rule_day;
				tod_q  <= rule_time;
				year_q <= calendar_year;
			end
			drtt_pkg::CMD_DIV: begin
				q100_q <= yprod[27:20];
			end
			drtt_pkg::CMD_PREP: begin
				leap_q <= leap_w;
				x_q    <= x_sum[9:0];
				if (kind_q == drtt_pkg::KIND_JULIAN) begin
					days_q <= $signed(jdays);
				end else begin
					days_q <= $signed({2'd0, rday_q});
				end
			end
			drtt_pkg::CMD_DOW: begin
				x_q <= {1'b0, rday_q} + 10'd7 - {7'd0, mod7(x_q)};
			end
			drtt_pkg::CMD_FIRST: begin
				days_q <= $signed({8'd0, mod7(x_q)});
				wk_q   <= week_q;
				m_q    <= 4'd1;
			end
			drtt_pkg::CMD_WEEK: begin
				wk_q   <= wk_q - 3'd1;
				days_q <= days_q + 11'sd7;
			end
			drtt_pkg::CMD_MONTH: begin
				days_q <= days_q + $signed({6'd0, ml_walk});
				m_q    <= m_q + 4'd1;
			end
			drtt_pkg::CMD_MUL: begin
				prod_q <= 28'(days_q) * 28'(DAY_SECONDS);
			end
			drtt_pkg::CMD_SUM: begin
				if ($signed(total) > 29'(drtt_pkg::SEC_MAX)) begin
					res_q <= drtt_pkg::SEC_MAX;
				end else if ($signed(total) < 29'(drtt_pkg::SEC_MIN)) begin
					res_q <= drtt_pkg::SEC_MIN;
				end else begin
					res_q <= total[drtt_pkg::SEC_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign seconds_into_year = res_q;

endmodule

@@ hdl/dst_rule_transition_time_core.sv @@
// ----------------------------------------------------------------------------
// dst_rule_transition_time_core
// Seconds from the start of a year to the instant of a daylight-saving rule.
//
// Channel   Direction  Handshake          Beat
// input     in         start / busy       rule_kind .. calendar_year
// result    out        done (one cycle)   seconds_into_year
//
// A beat is taken at a clock edge with start high and busy low; one result
// follows. J and plain day rules pass year split, preparation, scaling and
// output; M rules add the weekday search and the week and month walks in the
// day accumulator, one accumulator step per week step (up to 4) and per
// earlier month (up to 11). busy drops in the cycle after done.
// Reset clears the sequencer only. The receiver cannot stall; done is high
// for exactly one cycle.
// ----------------------------------------------------------------------------
module dst_rule_transition_time_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [drtt_pkg::KIND_W-1:0]       rule_kind,
	input  logic [drtt_pkg::MONTH_W-1:0]      rule_month,
	input  logic [drtt_pkg::WEEK_W-1:0]       rule_week,
	input  logic [drtt_pkg::DAY_W-1:0]        rule_day,
	input  logic signed [drtt_pkg::TOD_W-1:0] rule_time,
	input  logic [drtt_pkg::YEAR_W-1:0]       calendar_year,
	output logic                              done,
	output logic signed [drtt_pkg::SEC_W-1:0] seconds_into_year
);

	drtt_pkg::drtt_cmd_t  cmd;
	drtt_pkg::drtt_stat_t stat;

	drtt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	drtt_dp u_dp (
		.clk               (clk),
		.cmd               (cmd),
		.rule_kind         (rule_kind),
		.rule_month        (rule_month),
		.rule_week         (rule_week),
		.rule_day          (rule_day),
		.rule_time         (rule_time),
		.calendar_year     (calendar_year),
		.stat              (stat),
		.seconds_into_year (seconds_into_year)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_done_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done outside a busy period");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("done longer than one cycle or no return to idle");

	a_cmd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |-> cmd == drtt_pkg::CMD_NONE)
		else $error("datapath commanded while idle");

endmodule

@@ tb/tb_dst_rule_transition_time_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dst_rule_transition_time_core
// Self-checking bench for the daylight-saving rule transition time core.
//
// A queue of rule beats (directed corner cases, then random rules and years)
// feeds a clocked driver on the start / busy handshake with random gaps. An
// in-bench model of the calendar arithmetic predicts each seconds_into_year
// value at accept time, and a clocked monitor compares every done strobe
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_dst_rule_transition_time_core;

	localparam int CLK_HALF    = 5;
	localparam int RESET_CYC   = 11;
	localparam int RANDOM_BEATS = 1250;
	localparam int TAIL_CYC    = 40;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DAY_SEC     = 86400;
	localparam logic [15:0] LONG_MONTHS = 16'b0001_0101_1010_1010;
	localparam logic [drtt_pkg::KIND_W-1:0] KIND_DAYNUM = 2'd2;
	localparam logic [drtt_pkg::KIND_W-1:0] KIND_SPARE  = 2'd3;

	typedef struct {
		logic [drtt_pkg::KIND_W-1:0]        kind;
		logic [drtt_pkg::MONTH_W-1:0]       month;
		logic [drtt_pkg::WEEK_W-1:0]        week;
		logic [drtt_pkg::DAY_W-1:0]         day;
		logic signed [drtt_pkg::TOD_W-1:0]  tod;
		logic [drtt_pkg::YEAR_W-1:0]        year;
		int                                 gap;
		bit                                 drain;
	} rule_beat_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 start = 1'b0;
	logic                                 busy;
	logic [drtt_pkg::KIND_W-1:0]          rule_kind = '0;
	logic [drtt_pkg::MONTH_W-1:0]         rule_month = '0;
	logic [drtt_pkg::WEEK_W-1:0]          rule_week = '0;
	logic [drtt_pkg::DAY_W-1:0]           rule_day = '0;
	logic signed [drtt_pkg::TOD_W-1:0]    rule_time = '0;
	logic [drtt_pkg::YEAR_W-1:0]          calendar_year = '0;
	logic                                 done;
	logic signed [drtt_pkg::SEC_W-1:0]    seconds_into_year;

	rule_beat_t                           pending_beats[$];
	logic signed [drtt_pkg::SEC_W-1:0]    expected_seconds[$];
	int                                   gap_left = 0;
	int                                   errors = 0;
	int                                   cycles = 0;
	int                                   checked = 0;
	int                                   kind_count[4] = '{0, 0, 0, 0};
	int                                   saturated = 0;
	bit                                   quiet_run = 0;

	dst_rule_transition_time_core u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.rule_kind        (rule_kind),
		.rule_month       (rule_month),
		.rule_week        (rule_week),
		.rule_day         (rule_day),
		.rule_time        (rule_time),
		.calendar_year    (calendar_year),
		.done             (done),
		.seconds_into_year(seconds_into_year)
	);

	always #CLK_HALF clk = ~clk;

	function automatic int month_days(input int mon, input bit leap);
		if (mon == 2)
			return leap ? 29 : 28;
		return 30 + int'(LONG_MONTHS[mon & 15]);
	endfunction

	function automatic logic signed [drtt_pkg::SEC_W-1:0] transition_seconds(
		input logic [drtt_pkg::KIND_W-1:0] kind,
		input logic [drtt_pkg::MONTH_W-1:0] month_in,
		input logic [drtt_pkg::WEEK_W-1:0] week_in,
		input logic [drtt_pkg::DAY_W-1:0] day_in,
		input logic signed [drtt_pkg::TOD_W-1:0] tod_in,
		input logic [drtt_pkg::YEAR_W-1:0] year_in);
		int     yr, mon, wk, wday, zm, zy, dow, d;
		bit     leap;
		longint days, total;
		yr   = int'(year_in);
		mon  = int'(month_in);
		wk   = int'(week_in);
		wday = int'(day_in);
		leap = ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
		days = wday;
		if (kind == drtt_pkg::KIND_MWD) begin
			if (mon < 1) mon = 1;
			if (mon > 12) mon = 12;
			if (wk < 1) wk = 1;
			zm  = (mon + 9) % 12 + 1;
			zy  = yr - ((mon <= 2) ? 1 : 0);
			dow = ((26 * zm - 2) / 10 + 1 + (zy % 100) + (zy % 100) / 4
				+ (zy / 400) - 2 * (zy / 100)) % 7;
			if (dow < 0) dow += 7;
			d = (wday - dow + 7) % 7;
			while (wk > 1 && d + 7 < month_days(mon, leap)) begin
				wk--;
				d += 7;
			end
			for (int m = 1; m < mon; m++)
				d += month_days(m, leap);
			days = d;
		end else if (kind == drtt_pkg::KIND_JULIAN) begin
			days = wday - 1 + ((wday >= 31 + 29 && leap) ? 1 : 0);
		end
		total = longint'(tod_in) + days * DAY_SEC;
		if (total > longint'(drtt_pkg::SEC_MAX)) return drtt_pkg::SEC_MAX;
		if (total < longint'(drtt_pkg::SEC_MIN)) return drtt_pkg::SEC_MIN;
		return total[drtt_pkg::SEC_W-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		errors++;
	endtask

	task automatic add_beat(input logic [drtt_pkg::KIND_W-1:0] kind, input int month,
		input int week, input int day, input int tod, input int year);
		rule_beat_t b;
		b.kind  = kind;
		b.month = month[drtt_pkg::MONTH_W-1:0];
		b.week  = week[drtt_pkg::WEEK_W-1:0];
		b.day   = day[drtt_pkg::DAY_W-1:0];
		b.tod   = tod[drtt_pkg::TOD_W-1:0];
		b.year  = year[drtt_pkg::YEAR_W-1:0];
		b.gap   = quiet_run ? 0 : $urandom_range(0, 17);
		b.drain = 0;
		pending_beats = {pending_beats, b};
	endtask

	// driver: hold a beat until accepted, then wait its gap and drive the next
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				logic signed [drtt_pkg::SEC_W-1:0] secs;
				secs = transition_seconds(rule_kind, rule_month, rule_week, rule_day,
					rule_time, calendar_year);
				expected_seconds = {expected_seconds, secs};
				kind_count[rule_kind]++;
				if (secs == drtt_pkg::SEC_MAX || secs == drtt_pkg::SEC_MIN) saturated++;
				gap_left = (pending_beats.size() > 0) ? pending_beats[0].gap : 0;
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_beats.size() > 0 &&
				!(pending_beats[0].drain && expected_seconds.size() > 0)) begin
				rule_beat_t b;
				b = pending_beats.pop_front();
				rule_kind     <= b.kind;
				rule_month    <= b.month;
				rule_week     <= b.week;
				rule_day      <= b.day;
				rule_time     <= b.tod;
				calendar_year <= b.year;
				start         <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: one result per done strobe
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_seconds.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d", seconds_into_year));
			end else begin
				logic signed [drtt_pkg::SEC_W-1:0] want;
				want = expected_seconds.pop_front();
				checked++;
				if (seconds_into_year !== want)
					report_mismatch($sformatf("seconds_into_year got %0d expected %0d",
						seconds_into_year, want));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results pending", cycles,
				expected_seconds.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int r, kind_sel, month, week, day, tod, year;
		logic [drtt_pkg::KIND_W-1:0] kind;

		// directed corners
		add_beat(drtt_pkg::KIND_MWD, 3, 2, 0, 7200, 2024);
		add_beat(drtt_pkg::KIND_MWD, 0, 0, 0, 0, 2023);
		add_beat(drtt_pkg::KIND_MWD, 15, 7, 6, 0, 2023);
		add_beat(drtt_pkg::KIND_MWD, 10, 5, 0, 3600, 2021);
		add_beat(drtt_pkg::KIND_MWD, 2, 5, 4, 0, 2000);
		add_beat(drtt_pkg::KIND_MWD, 2, 5, 4, 0, 1900);
		add_beat(drtt_pkg::KIND_MWD, 1, 1, 511, -1048576, 0);
		add_beat(drtt_pkg::KIND_MWD, 2, 3, 7, 1048575, 0);
		add_beat(drtt_pkg::KIND_MWD, 12, 5, 3, 604800, 16383);
		add_beat(drtt_pkg::KIND_MWD, 11, 1, 256, -604800, 1);
		add_beat(drtt_pkg::KIND_JULIAN, 0, 0, 0, 0, 2023);
		add_beat(drtt_pkg::KIND_JULIAN, 0, 0, 59, 0, 2024);
		add_beat(drtt_pkg::KIND_JULIAN, 0, 0, 60, 0, 2024);
		add_beat(drtt_pkg::KIND_JULIAN, 0, 0, 60, 0, 2023);
		add_beat(drtt_pkg::KIND_JULIAN, 0, 0, 365, 86399, 2024);
		add_beat(drtt_pkg::KIND_JULIAN, 0, 0, 511, 1048575, 0);
		add_beat(KIND_DAYNUM, 0, 0, 0, -1048576, 9999);
		add_beat(KIND_DAYNUM, 0, 0, 365, 0, 2024);
		add_beat(KIND_DAYNUM, 15, 7, 511, 1048575, 16383);
		add_beat(KIND_SPARE, 5, 3, 100, 43200, 2020);
		add_beat(KIND_SPARE, 0, 0, 388, 1048575, 8191);
		add_beat(drtt_pkg::KIND_JULIAN, 15, 7, 366, -1, 400);

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			quiet_run = ((i / 60) % 5) == 2;
			kind_sel = $urandom_range(0, 9);
			kind = (kind_sel < 6) ? drtt_pkg::KIND_MWD :
				(kind_sel < 8) ? drtt_pkg::KIND_JULIAN :
				(kind_sel < 9) ? KIND_DAYNUM : KIND_SPARE;
			r = $urandom_range(0, 7);
			month = (r == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
			week  = $urandom_range(0, 7);
			if (kind == drtt_pkg::KIND_MWD)
				day = (r == 1) ? $urandom_range(0, 511) : $urandom_range(0, 6);
			else if (kind == drtt_pkg::KIND_JULIAN)
				day = (r == 1) ? $urandom_range(0, 511) : $urandom_range(1, 365);
			else
				day = (r == 1) ? $urandom_range(0, 511) : $urandom_range(0, 365);
			tod = (r == 2) ? int'($urandom_range(0, 2097151)) - 1048576
				: int'($urandom_range(0, 1209600)) - 604800;
			year = (r == 3) ? $urandom_range(0, 16383) : $urandom_range(1, 9999);
			add_beat(kind, month, week, day, tod, year);
			if (i % 250 == 0)
				pending_beats[$].drain = 1;
		end

		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_beats.size() > 0 || start || expected_seconds.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
		if (expected_seconds.size() > 0)
			report_mismatch($sformatf("%0d results never arrived", expected_seconds.size()));

		$display("Checked %0d transition results in %0d cycles, %0d saturated", checked,
			cycles, saturated);
		$display("Rule mix: M %0d, Julian %0d, day number %0d, spare kind %0d",
			kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/drtt_pkg.sv
hdl/drtt_ctrl.sv
hdl/drtt_dp.sv
hdl/dst_rule_transition_time_core.sv
tb/tb_dst_rule_transition_time_core.sv
